>>> rtl/core/dq_pkg.sv
// Shared types and constants for the double-ended queue.
// No dependencies; imported by the controller, datapath and top level.
package dq_pkg;

  // Ring store geometry (capacity must be a power of two)
  localparam int CAPACITY = 64;
  localparam int PTR_W    = $clog2(CAPACITY);
  localparam int CNT_W    = PTR_W + 1;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 6;
  localparam int OCC_W    = 7;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SWAP       = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Store address source
  typedef enum logic [2:0] {
    A_PUSH_FRONT = 3'd0,
    A_PUSH_BACK  = 3'd1,
    A_POP_FRONT  = 3'd2,
    A_POP_BACK   = 3'd3,
    A_POS_FIRST  = 3'd4,
    A_POS_SECOND = 3'd5
  } addr_sel_e;

  // Store write data source
  typedef enum logic [1:0] {
    W_PUSH  = 2'd0,
    W_RDATA = 2'd1,
    W_HELD  = 2'd2
  } wdata_sel_e;

  typedef struct packed {
    logic [2:0]               opcode;
    logic signed [DATA_W-1:0] push_value;
    logic [POS_W-1:0]         first_position;
    logic [POS_W-1:0]         second_position;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic [1:0]               status;
    logic [OCC_W-1:0]         occupancy;
  } out_word_t;

  // Controller -> datapath
  typedef struct packed {
    logic       load;    // latch the accepted word
    logic       mem_rd;
    logic       mem_wr;
    addr_sel_e  addr_sel;
    wdata_sel_e wdata_sel;
    logic       hold;    // capture read data into the swap holding register
    logic       commit;  // update front pointer and count
    logic       emit;    // load the result register
  } dq_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic [2:0] op;
    logic       fail;     // full, empty or out of range for the latched op
    logic       out_free; // result register can take a word this cycle
  } dq_sts_t;

endpackage

>>> rtl/core/dq_ctrl.sv
// Command sequencer for the double-ended queue.
// Depends on dq_pkg; drives dq_datapath through dq_cmd_t.
module dq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  dq_pkg::dq_sts_t sts,
  output dq_pkg::dq_cmd_t cmd
);
  import dq_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_EXEC     = 6'b000010,
    S_POP_DONE = 6'b000100,
    S_SWAP_B   = 6'b001000,
    S_SWAP_WA  = 6'b010000,
    S_SWAP_WB  = 6'b100000
  } state_e;

  state_e state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode
  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.mem_rd    = 1'b0;
    cmd.mem_wr    = 1'b0;
    cmd.addr_sel  = A_POP_FRONT;
    cmd.wdata_sel = W_PUSH;
    cmd.hold      = 1'b0;
    cmd.commit    = 1'b0;
    cmd.emit      = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.fail) begin
          // rejected command: report status only
          if (sts.out_free) begin
            cmd.emit   = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          unique case (sts.op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (sts.out_free) begin
                cmd.mem_wr    = 1'b1;
                cmd.addr_sel  = (sts.op == OP_PUSH_FRONT) ? A_PUSH_FRONT : A_PUSH_BACK;
                cmd.wdata_sel = W_PUSH;
                cmd.commit    = 1'b1;
                cmd.emit      = 1'b1;
                state_next    = S_IDLE;
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              cmd.mem_rd   = 1'b1;
              cmd.addr_sel = (sts.op == OP_POP_FRONT) ? A_POP_FRONT : A_POP_BACK;
              state_next   = S_POP_DONE;
            end
            OP_SWAP: begin
              cmd.mem_rd   = 1'b1;
              cmd.addr_sel = A_POS_FIRST;
              state_next   = S_SWAP_B;
            end
            default: begin
              // unused opcode: ok status, no change
              if (sts.out_free) begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
              end
            end
          endcase
        end
      end
      S_POP_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SWAP_B: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = A_POS_SECOND;
        cmd.hold     = 1'b1;
        state_next   = S_SWAP_WA;
      end
      S_SWAP_WA: begin
        cmd.mem_wr    = 1'b1;
        cmd.addr_sel  = A_POS_FIRST;
        cmd.wdata_sel = W_RDATA;
        state_next    = S_SWAP_WB;
      end
      S_SWAP_WB: begin
        if (sts.out_free) begin
          cmd.mem_wr    = 1'b1;
          cmd.addr_sel  = A_POS_SECOND;
          cmd.wdata_sel = W_HELD;
          cmd.emit      = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Single-port store: never read and write together
  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mem_rd && cmd.mem_wr))
    else $error("store read and write in one cycle");

  // A result is only produced into a free result register
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("result emitted into a busy register");

  // Holding capture always follows the first swap read
  a_hold_seq: assert property (@(posedge clk) disable iff (rst)
    cmd.hold |-> $past(cmd.mem_rd && cmd.addr_sel == A_POS_FIRST))
    else $error("swap holding capture out of sequence");

endmodule

>>> rtl/core/dq_datapath.sv
// Ring store, front pointer, count and result register of the queue.
// Depends on dq_pkg; sequenced by dq_ctrl.
module dq_datapath (
  input  logic              clk,
  input  logic              rst,
  input  dq_pkg::in_word_t  in_data,
  input  dq_pkg::dq_cmd_t   cmd,
  output dq_pkg::dq_sts_t   sts,
  input  logic              out_ready,
  output logic              out_valid,
  output dq_pkg::out_word_t out_data
);
  import dq_pkg::*;

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rdata;
  logic [DATA_W-1:0] held;
  logic [DATA_W-1:0] wdata;
  logic [PTR_W-1:0]  addr;
  in_word_t          word;
  logic [PTR_W-1:0]  front, front_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              full, empty, range_bad, fail;
  logic              is_pop;
  status_e           status_code;
  logic [PTR_W-1:0]  slot_first, slot_second;

  // Latched command word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word <= in_data;
    end
  end

  // Condition checks
  assign full      = (count == CNT_W'(CAPACITY));
  assign empty     = (count == '0);
  assign range_bad = (CNT_W'(word.first_position) >= count) ||
                     (CNT_W'(word.second_position) >= count);
  assign is_pop    = (word.opcode == OP_POP_FRONT) || (word.opcode == OP_POP_BACK);

  always_comb begin
    fail        = 1'b0;
    status_code = ST_OK;
    case (word.opcode)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        fail        = full;
        status_code = full ? ST_FULL : ST_OK;
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        fail        = empty;
        status_code = empty ? ST_EMPTY : ST_OK;
      end
      OP_SWAP: begin
        fail        = range_bad;
        status_code = range_bad ? ST_RANGE : ST_OK;
      end
      default: begin
        fail        = 1'b0;
        status_code = ST_OK;
      end
    endcase
  end

  assign sts.op       = word.opcode;
  assign sts.fail     = fail;
  assign sts.out_free = !out_valid || out_ready;

  // Ring slot addressing
  assign slot_first  = front + PTR_W'(word.first_position);
  assign slot_second = front + PTR_W'(word.second_position);

  always_comb begin
    case (cmd.addr_sel)
      A_PUSH_FRONT: addr = front - PTR_W'(1);
      A_PUSH_BACK:  addr = front + count[PTR_W-1:0];
      A_POP_FRONT:  addr = front;
      A_POP_BACK:   addr = front + count[PTR_W-1:0] - PTR_W'(1);
      A_POS_FIRST:  addr = slot_first;
      A_POS_SECOND: addr = slot_second;
      default:      addr = front;
    endcase
  end

  always_comb begin
    case (cmd.wdata_sel)
      W_PUSH:  wdata = word.push_value;
      W_RDATA: wdata = rdata;
      W_HELD:  wdata = held;
      default: wdata = word.push_value;
    endcase
  end

  // Single-port store with registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.mem_rd) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hold) begin
      held <= rdata;
    end
  end

  // Pointer and count update
  always_comb begin
    front_next = front;
    count_next = count;
    if (cmd.commit) begin
      case (word.opcode)
        OP_PUSH_FRONT: begin
          front_next = front - PTR_W'(1);
          count_next = count + CNT_W'(1);
        end
        OP_PUSH_BACK: count_next = count + CNT_W'(1);
        OP_POP_FRONT: begin
          front_next = front + PTR_W'(1);
          count_next = count - CNT_W'(1);
        end
        OP_POP_BACK: count_next = count - CNT_W'(1);
        default: begin
          front_next = front;
          count_next = count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else begin
      front <= front_next;
      count <= count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.popped_value <= (is_pop && !fail) ? rdata : '0;
      out_data.status       <= status_code;
      out_data.occupancy    <= OCC_W'(count_next);
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && is_pop) |=> (count == $past(count) - CNT_W'(1)))
    else $error("pop did not decrement count");

  a_fail_no_commit: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && fail) |-> 1'b0)
    else $error("rejected command changed the queue");

endmodule

>>> rtl/core/double_ended_queue.sv
// Top level of the bounded double-ended queue of signed 32-bit words.
// Depends on dq_pkg, dq_ctrl and dq_datapath.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one command word:
//   push front, push back, pop front, pop back or swap of two positions.
//   Output channel out_valid/out_ready/out_data returns one result word per
//   command: popped value (zero unless a pop succeeded), status and the
//   occupancy after the command.
//   A push, a rejected or an unused command emits its result from the
//   execute state; a pop and a swap emit from later states. The next command is
//   accepted in the cycle the result appears. The pace is set by the
//   single-port ring store: a pop waits on its registered read, a swap
//   needs two reads and two writes.
//   Reset clears the front pointer, the count and the result valid flag;
//   the store contents are not cleared and are only read once written.
//   When the receiver stalls, the finished result waits in the output
//   register; the next command is still accepted and executes up to the
//   point of producing its result, then holds until the register frees.
module double_ended_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dq_pkg::in_word_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output dq_pkg::out_word_t out_data
);
  import dq_pkg::*;

  dq_cmd_t cmd;
  dq_sts_t sts;

  dq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dq_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
